### src/oist_pkg.sv
`default_nettype none
package oist_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OPCODE_W  = 2;
  localparam int IN_VAL_W  = 32;
  localparam int POS_W     = 6;
  localparam int ELEM_W    = 32;
  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_IDX  = 2'd1,
    RD_IDX1 = 2'd2,
    RD_POS  = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    rd_sel_t rd_sel;
    logic    idx_inc;
    logic    append;
    logic    shift_wr;
    logic    count_dec;
    logic    set_found;
    logic    set_full;
    logic    set_range;
    logic    set_elem;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic hit;
    logic scan_end;
    logic shift_end;
    logic full;
    logic pos_ok;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### src/oist_if.sv
`default_nettype none
interface oist_in_if;
  import oist_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [IN_VAL_W-1:0] value;
  logic [POS_W-1:0]           position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface oist_out_if;
  import oist_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     found;
  logic signed [ELEM_W-1:0] element;
  logic [COUNT_W-1:0]       entry_count;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output found, output element, output entry_count,
                  output status, input ready);
  modport sink   (input valid, input found, input element, input entry_count,
                  input status, output ready);
endinterface
`default_nettype wire

### src/oist_datapath.sv
`default_nettype none
module oist_datapath #(
  parameter int DEPTH       = oist_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = oist_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire oist_pkg::cmd_t                      cmd,
  output oist_pkg::sts_t                           sts,
  input  wire logic [oist_pkg::OPCODE_W-1:0]       in_opcode,
  input  wire logic signed [oist_pkg::IN_VAL_W-1:0] in_value,
  input  wire logic [oist_pkg::POS_W-1:0]          in_position,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_found,
  output logic signed [oist_pkg::ELEM_W-1:0]       out_element,
  output logic [oist_pkg::COUNT_W-1:0]             out_entry_count,
  output logic [oist_pkg::STATUS_W-1:0]            out_status
);
  import oist_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = VALUE_WIDTH;

  logic [VW-1:0] mem [DEPTH];
  logic [VW-1:0] rdata_r;

  op_t           op_r;
  logic [VW-1:0] val_r;
  logic [POS_W-1:0] pos_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic          found_r;
  status_t       status_r;
  logic [ELEM_W-1:0] elem_r;

  logic                 out_valid_r;
  logic                 out_found_r;
  logic [ELEM_W-1:0]    out_elem_r;
  logic [COUNT_W-1:0]   out_count_r;
  logic [STATUS_W-1:0]  out_status_r;

  logic [VW+IN_VAL_W-1:0] vin_ext;
  logic [VW+ELEM_W-1:0]   elem_ext;
  logic [AW+POS_W-1:0]    pos_ext;
  logic [CW+COUNT_W-1:0]  cnt_ext;
  logic [CW-1:0]          idx1;
  logic [AW-1:0]          rd_addr;
  logic                   rd_en;
  logic                   we;
  logic [AW-1:0]          wa;
  logic [VW-1:0]          wd;

  assign vin_ext  = {{VW{in_value[IN_VAL_W-1]}}, in_value};
  assign elem_ext = {{ELEM_W{rdata_r[VW-1]}}, rdata_r};
  assign pos_ext  = {{AW{1'b0}}, pos_r};
  assign cnt_ext  = {{COUNT_W{1'b0}}, count_r};
  assign idx1     = idx_r + CW'(1);

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = idx_r[AW-1:0];
    unique case (cmd.rd_sel)
      RD_NONE: rd_en   = 1'b0;
      RD_IDX:  rd_addr = idx_r[AW-1:0];
      RD_IDX1: rd_addr = idx1[AW-1:0];
      RD_POS:  rd_addr = pos_ext[AW-1:0];
      default: rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    we = cmd.append | cmd.shift_wr;
    if (cmd.append) begin
      wa = count_r[AW-1:0];
      wd = val_r;
    end else begin
      wa = idx_r[AW-1:0];
      wd = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op_t'(in_opcode);
      val_r    <= vin_ext[VW-1:0];
      pos_r    <= in_position;
      found_r  <= 1'b0;
      status_r <= ST_OK;
      elem_r   <= '0;
    end else begin
      if (cmd.set_found) begin
        found_r <= 1'b1;
      end
      if (cmd.set_full) begin
        status_r <= ST_FULL;
      end
      if (cmd.set_range) begin
        status_r <= ST_RANGE;
      end
      if (cmd.set_elem) begin
        elem_r <= elem_ext[ELEM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.idx_inc || cmd.shift_wr) begin
        idx_r <= idx1;
      end
      if (cmd.append) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.count_dec) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found_r  <= found_r;
      out_elem_r   <= elem_r;
      out_count_r  <= cnt_ext[COUNT_W-1:0];
      out_status_r <= status_r;
    end
  end

  assign sts.op        = op_r;
  assign sts.hit       = (rdata_r == val_r);
  assign sts.scan_end  = (idx_r == count_r);
  assign sts.shift_end = ({1'b0, idx1} >= {1'b0, count_r});
  assign sts.full      = (count_r == CW'(DEPTH));
  assign sts.pos_ok    = ({{CW{1'b0}}, pos_r} < {{POS_W{1'b0}}, count_r});
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_element     = out_elem_r;
  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;

endmodule
`default_nettype wire

### src/oist_ctrl.sv
`default_nettype none
module oist_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire oist_pkg::sts_t sts,
  output oist_pkg::cmd_t      cmd
);
  import oist_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_CMP,
    S_SHIFT,
    S_SHIFT_WR,
    S_RD_WAIT,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;
  logic   in_fire;

  assign in_fire  = in_valid && in_ready_r;
  assign in_ready = in_ready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.op == OP_READ) begin
          if (sts.pos_ok) begin
            cmd.rd_sel = RD_POS;
            state_nxt  = S_RD_WAIT;
          end else begin
            cmd.set_range = 1'b1;
            state_nxt     = S_FIN;
          end
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          if (sts.op == OP_INSERT) begin
            if (sts.full) begin
              cmd.set_full = 1'b1;
            end else begin
              cmd.append = 1'b1;
            end
          end
          state_nxt = S_FIN;
        end else begin
          cmd.rd_sel = RD_IDX;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          cmd.set_found = 1'b1;
          state_nxt     = (sts.op == OP_REMOVE) ? S_SHIFT : S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SHIFT: begin
        if (sts.shift_end) begin
          cmd.count_dec = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          cmd.rd_sel = RD_IDX1;
          state_nxt  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHIFT;
      end
      S_RD_WAIT: begin
        cmd.set_elem = 1'b1;
        state_nxt    = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule
`default_nettype wire

### src/ordered_integer_set_table_top.sv
// Ordered integer set table: distinct signed values kept in insertion order.
// in_req carries a request (opcode, value, position); out_rsp returns one
// response per request (found, element, entry_count, status).
// Opcodes: insert appends an absent value, remove deletes a value and closes
// the gap, lookup reports membership, read returns the entry at a position.
// Entries sit in a single-port-write, registered-read memory that a
// controller walks one entry at a time, reading it and then comparing it.
// A read registers the entry at its position and returns it; a read whose
// position is at or beyond the entry count returns a range status without
// a memory read. Insert, remove and lookup read and compare the entries in
// order until the value is found or every entry held has been compared;
// a remove that finds its value then moves each entry behind it down one.
// One request is worked on at a time; the next one can be accepted as soon
// as the response is in the output register, and a stalled receiver holds
// at most one response while the following request runs.
// When out_rsp.ready stays low with a response waiting, the finished request
// holds in the controller and in_req.ready stays low.
// Reset empties the set at once; memory contents are not cleared.
`default_nettype none
module ordered_integer_set_table_top #(
  parameter int DEPTH       = oist_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = oist_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  oist_in_if.sink     in_req,
  oist_out_if.source  out_rsp
);
  import oist_pkg::*;

  cmd_t cmd;
  sts_t sts;

  oist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  oist_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_req.opcode),
    .in_value        (in_req.value),
    .in_position     (in_req.position),
    .out_valid       (out_rsp.valid),
    .out_ready       (out_rsp.ready),
    .out_found       (out_rsp.found),
    .out_element     (out_rsp.element),
    .out_entry_count (out_rsp.entry_count),
    .out_status      (out_rsp.status)
  );

endmodule
`default_nettype wire
